// ===== rtl/csmacd_pkg.sv =====
package csmacd_pkg;

  // Frame store depth and the address width that follows from it.
  localparam int MAX_FRAME = 64;
  localparam int STORE_AW  = $clog2(MAX_FRAME);

  // Item operations carried in the slave tuser.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FPM  = 2'd0;
  localparam logic [1:0] REG_FLEN = 2'd1;
  localparam logic [1:0] REG_JAM  = 2'd2;
  localparam logic [1:0] REG_MBE  = 2'd3;

  // Line phases of the transmitter.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_WAIT    = 3'd1;
  localparam logic [2:0] PH_SEND    = 3'd2;
  localparam logic [2:0] PH_JAM     = 3'd3;
  localparam logic [2:0] PH_BACKOFF = 3'd4;

  typedef struct packed {
    logic [7:0] fpm;
    logic [6:0] flen;
    logic [7:0] jam;
    logic [3:0] mbe;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  load_index;
    logic [7:0]  data_byte;
    logic        line_busy;
    logic [7:0]  line_byte;
    logic [15:0] random_value;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       jamming;
    logic       collision;
    logic       frame_sent;
    logic       message_done;
    logic [3:0] attempt_count;
    logic       active;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic rd_next;
    logic latch_expect;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic backoff_go;
    logic mod_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/csmacd_regs.sv =====
module csmacd_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output csmacd_pkg::cfg_t   cfg
);
  import csmacd_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes in the access cycle of a write transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fpm  <= 8'd1;
      cfg.flen <= 7'd1;
      cfg.jam  <= 8'd0;
      cfg.mbe  <= 4'd10;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_FPM:  cfg.fpm  <= pwdata[7:0];
        REG_FLEN: cfg.flen <= pwdata[6:0];
        REG_JAM:  cfg.jam  <= pwdata[7:0];
        REG_MBE:  cfg.mbe  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (paddr[3:2])
      REG_FPM:  prdata = {24'd0, cfg.fpm};
      REG_FLEN: prdata = {25'd0, cfg.flen};
      REG_JAM:  prdata = {24'd0, cfg.jam};
      REG_MBE:  prdata = {28'd0, cfg.mbe};
      default:  prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/csmacd_mod.sv =====
module csmacd_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] value,
  input  logic [3:0]  expo,
  output logic        done,
  output logic [14:0] rem
);

  logic        busy;
  logic [15:0] x;
  logic [3:0]  e;
  logic [15:0] modulus;
  logic [15:0] fold;

  // Remainder by 2^e - 1: fold the high part onto the low part until the
  // value no longer exceeds the modulus. Each fold strictly shrinks it.
  assign modulus = (16'd1 << e) - 16'd1;
  assign fold    = (x & modulus) + (x >> e);
  assign done    = busy && (x <= modulus);
  assign rem     = (x == modulus) ? 15'd0 : x[14:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= value;
      e <= expo;
    end else if (busy && !done) begin
      x <= fold;
    end
  end

endmodule

// ===== rtl/csmacd_dpath.sv =====
module csmacd_dpath (
  input  logic                   clk,
  input  logic                   rst,
  input  csmacd_pkg::cfg_t       cfg,
  input  csmacd_pkg::item_t      item_in,
  input  csmacd_pkg::ctrl_cmd_t  cmd,
  output csmacd_pkg::dp_stat_t   stat,
  input  logic                   out_take,
  output logic                   out_valid,
  output csmacd_pkg::res_t       out_res
);
  import csmacd_pkg::*;

  // Frame store and its registered read port.
  logic [7:0]          store [MAX_FRAME];
  logic [7:0]          rd_data;
  logic [STORE_AW-1:0] rd_addr;
  logic [6:0]          exp_pos;

  // Captured item and the expected readback byte.
  item_t      item;
  logic [7:0] expect_byte;

  // Transmitter state.
  logic [2:0]  phase, phase_next;
  logic [6:0]  byte_position, byte_position_next;
  logic [3:0]  attempt, attempt_next;
  logic [14:0] backoff_left, backoff_left_next;
  logic [7:0]  frames_done, frames_done_next;

  // Per-item flags held until the result is loaded.
  logic       p_tv, p_jm, p_col, p_fs, p_md;
  logic [7:0] p_tb;
  logic       tv, jm, col, fs, md, go;
  logic [7:0] tb;

  logic [6:0]  len_eff;
  logic [7:0]  fpm_eff;
  logic [3:0]  cap;
  logic [4:0]  att_inc;
  logic [3:0]  att_bo;
  logic [6:0]  bp_inc;
  logic [7:0]  fd_inc;
  logic        mod_done;
  logic [14:0] mod_rem;

  // Effective register values with zero and overrange cases folded in.
  assign len_eff = (cfg.flen == 7'd0) ? 7'd1 :
                   ((cfg.flen > 7'(MAX_FRAME)) ? 7'(MAX_FRAME) : cfg.flen);
  assign fpm_eff = (cfg.fpm == 8'd0) ? 8'd1 : cfg.fpm;
  assign cap     = (cfg.mbe == 4'd0) ? 4'd1 : cfg.mbe;
  assign att_inc = {1'b0, attempt} + 5'd1;
  assign att_bo  = (att_inc > {1'b0, cap}) ? cap : att_inc[3:0];
  assign bp_inc  = byte_position + 7'd1;
  assign fd_inc  = frames_done + 8'd1;

  // First read fetches the byte driven last tick, the second the next one.
  assign exp_pos = (byte_position != 7'd0) ? (byte_position - 7'd1) : 7'd0;
  assign rd_addr = cmd.rd_next ?
                   ((phase == PH_WAIT) ? '0 : byte_position[STORE_AW-1:0]) :
                   exp_pos[STORE_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.exec && item.operation == OP_LOAD) begin
      store[item.load_index] <= item.data_byte;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= item_in;
    end
    if (cmd.latch_expect) begin
      expect_byte <= rd_data;
    end
  end

  // Next state of one item.
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    attempt_next       = attempt;
    backoff_left_next  = backoff_left;
    frames_done_next   = frames_done;
    tv  = 1'b0;
    tb  = 8'd0;
    jm  = 1'b0;
    col = 1'b0;
    fs  = 1'b0;
    md  = 1'b0;
    go  = 1'b0;
    case (item.operation)
      OP_START: begin
        if (phase == PH_IDLE) begin
          phase_next         = PH_WAIT;
          frames_done_next   = 8'd0;
          attempt_next       = 4'd0;
          byte_position_next = 7'd0;
          backoff_left_next  = 15'd0;
        end
      end
      OP_TICK: begin
        case (phase)
          PH_WAIT: begin
            if (!item.line_busy) begin
              tv = 1'b1;
              tb = rd_data;
              byte_position_next = 7'd1;
              phase_next = PH_SEND;
            end
          end
          PH_SEND: begin
            if (item.line_byte != expect_byte) begin
              col = 1'b1;
              tv  = 1'b1;
              tb  = cfg.jam;
              jm  = 1'b1;
              byte_position_next = 7'd1;
              phase_next = PH_JAM;
              go = (len_eff <= 7'd1);
            end else if (byte_position < len_eff) begin
              tv = 1'b1;
              tb = rd_data;
              byte_position_next = bp_inc;
            end else begin
              fs = 1'b1;
              attempt_next       = 4'd0;
              byte_position_next = 7'd0;
              frames_done_next   = fd_inc;
              if (fd_inc >= fpm_eff) begin
                md = 1'b1;
                phase_next = PH_IDLE;
              end else begin
                phase_next = PH_WAIT;
              end
            end
          end
          PH_JAM: begin
            tv = 1'b1;
            tb = cfg.jam;
            jm = 1'b1;
            byte_position_next = bp_inc;
            go = (bp_inc >= len_eff);
          end
          PH_BACKOFF: begin
            if (backoff_left != 15'd0) begin
              backoff_left_next = backoff_left - 15'd1;
            end
            if (backoff_left <= 15'd1) begin
              phase_next = PH_WAIT;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // Jam complete: raise the attempt count up to the limit; the backoff length follows.
    if (go) begin
      attempt_next       = att_bo;
      byte_position_next = 7'd0;
    end
  end

  csmacd_mod u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.exec & go),
    .value (item.random_value),
    .expo  (att_bo),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // State update at execution and at the end of the backoff computation.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= 7'd0;
      attempt       <= 4'd0;
      backoff_left  <= 15'd0;
      frames_done   <= 8'd0;
    end else if (cmd.exec) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      attempt       <= attempt_next;
      backoff_left  <= backoff_left_next;
      frames_done   <= frames_done_next;
    end else if (mod_done) begin
      backoff_left <= mod_rem;
      phase        <= (mod_rem != 15'd0) ? PH_BACKOFF : PH_WAIT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      p_tv  <= tv;
      p_tb  <= tb;
      p_jm  <= jm;
      p_col <= col;
      p_fs  <= fs;
      p_md  <= md;
    end
  end

  // Output register, freed when the master-side transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_res.tx_valid      <= p_tv;
      out_res.tx_byte       <= p_tb;
      out_res.jamming       <= p_jm;
      out_res.collision     <= p_col;
      out_res.frame_sent    <= p_fs;
      out_res.message_done  <= p_md;
      out_res.attempt_count <= attempt;
      out_res.active        <= (phase != PH_IDLE);
    end
  end

  assign stat.backoff_go = go;
  assign stat.mod_done   = mod_done;
  assign stat.out_free   = !out_valid || out_take;

endmodule

// ===== rtl/csmacd_ctrl.sv =====
module csmacd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  csmacd_pkg::dp_stat_t   stat,
  output csmacd_pkg::ctrl_cmd_t  cmd
);
  import csmacd_pkg::*;

  localparam logic [2:0] ST_IN  = 3'd0;
  localparam logic [2:0] ST_RD0 = 3'd1;
  localparam logic [2:0] ST_RD1 = 3'd2;
  localparam logic [2:0] ST_EXE = 3'd3;
  localparam logic [2:0] ST_MOD = 3'd4;
  localparam logic [2:0] ST_OUT = 3'd5;

  logic [2:0] state, state_next;

  assign in_ready = (state == ST_IN);

  // Sequencing of one item: capture, two store reads, execute, optional
  // backoff remainder, then hand-off to the output register.
  always_comb begin
    state_next       = state;
    cmd.capture      = 1'b0;
    cmd.rd_next      = 1'b0;
    cmd.latch_expect = 1'b0;
    cmd.exec         = 1'b0;
    cmd.load_out     = 1'b0;
    case (state)
      ST_IN: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_RD0;
        end
      end
      ST_RD0: begin
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_next      = 1'b1;
        cmd.latch_expect = 1'b1;
        state_next       = ST_EXE;
      end
      ST_EXE: begin
        cmd.exec   = 1'b1;
        state_next = stat.backoff_go ? ST_MOD : ST_OUT;
      end
      ST_MOD: begin
        if (stat.mod_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IN;
        end
      end
      default: begin
        state_next = ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IN;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/csma_cd_frame_transmitter.sv =====
// Channel   Direction  Transaction
// s_*       in         one item: load, start or line tick
// m_*       out        one result per item
// APB       in         register writes and reads, always ready
//
// Each item goes through capture, two frame store reads on the single read
// port, execute and hand-off, which loads its result into the output register.
// An item that ends a jam also waits in the folding remainder unit that sizes
// the backoff.
// Reset is synchronous, active high. A stalled m_tready holds the hand-off.
// The next item is accepted while a result still waits on a stalled m_tready.
module csma_cd_frame_transmitter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [5:0] load_index, [13:6] data_byte, [14] line_busy, [22:15] line_byte,
  // [38:23] random_value, [39] zero
  input  logic [39:0] s_tdata,
  // [1:0] operation
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] collision, [10] frame_sent,
  // [11] message_done, [15:12] attempt_count, [16] active, [23:17] zero
  output logic [23:0] m_tdata,
  // [0] jamming
  output logic        m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import csmacd_pkg::*;

  cfg_t      cfg;
  item_t     item_in;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  res_t      res;

  // Unpack the slave-side transaction.
  assign item_in.operation    = s_tuser;
  assign item_in.load_index   = s_tdata[5:0];
  assign item_in.data_byte    = s_tdata[13:6];
  assign item_in.line_busy    = s_tdata[14];
  assign item_in.line_byte    = s_tdata[22:15];
  assign item_in.random_value = s_tdata[38:23];

  csmacd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csmacd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csmacd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_in   (item_in),
    .cmd       (cmd),
    .stat      (stat),
    .out_take  (m_tvalid & m_tready),
    .out_valid (m_tvalid),
    .out_res   (res)
  );

  // Pack the master-side transaction.
  assign m_tdata = {7'd0, res.active, res.attempt_count, res.message_done,
                    res.frame_sent, res.collision, res.tx_byte, res.tx_valid};
  assign m_tuser = res.jamming;

endmodule

// ===== test/csma_cd_frame_transmitter_test.sv =====
module csma_cd_frame_transmitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csmacd_pkg::*;

  // The fourth operation code has no meaning and must be ignored.
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int IDLE_PCT = 28;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 30;

  // Results that can be read straight off the behaviour after reset.
  localparam res_t RES_NONE = '0;
  localparam res_t RES_ARMED = '{active: 1'b1, default: '0};
  localparam res_t RES_JAM_RETRY = '{tx_valid: 1'b1, jamming: 1'b1, collision: 1'b1,
                                     attempt_count: 4'd1, active: 1'b1, default: '0};
  localparam res_t RES_MSG_DONE = '{frame_sent: 1'b1, message_done: 1'b1, default: '0};

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  idx;
    logic [7:0]  data;
    logic        busy;
    logic [7:0]  readback;
    logic [15:0] rnd;
    bit          typed;
    res_t        want;
  } step_row_t;

  // Directed opening run, all at the reset register values.
  step_row_t plan [13] = '{
    '{OP_TICK,  6'd0,  8'h00, 1'b1, 8'hFF, 16'hFFFF, 1'b1, RES_NONE},
    '{OP_NONE,  6'd63, 8'hFF, 1'b1, 8'hFF, 16'hFFFF, 1'b1, RES_NONE},
    '{OP_LOAD,  6'd0,  8'hFF, 1'b0, 8'h00, 16'h0000, 1'b1, RES_NONE},
    '{OP_LOAD,  6'd63, 8'h00, 1'b1, 8'hFF, 16'h0000, 1'b1, RES_NONE},
    '{OP_LOAD,  6'd1,  8'h81, 1'b0, 8'h00, 16'h0000, 1'b1, RES_NONE},
    '{OP_START, 6'd0,  8'h00, 1'b0, 8'h00, 16'h0000, 1'b1, RES_ARMED},
    '{OP_START, 6'd0,  8'h00, 1'b0, 8'h00, 16'h0000, 1'b1, RES_ARMED},
    '{OP_TICK,  6'd0,  8'h00, 1'b1, 8'h00, 16'h0000, 1'b1, RES_ARMED},
    '{OP_TICK,  6'd0,  8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, RES_NONE},
    '{OP_TICK,  6'd0,  8'h00, 1'b0, 8'h00, 16'hFFFF, 1'b1, RES_JAM_RETRY},
    '{OP_TICK,  6'd0,  8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, RES_NONE},
    '{OP_TICK,  6'd0,  8'h00, 1'b0, 8'hFF, 16'h0000, 1'b1, RES_MSG_DONE},
    '{OP_TICK,  6'd0,  8'h00, 1'b0, 8'h00, 16'h0000, 1'b1, RES_NONE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Transmitter state as the testbench predicts it.
  logic [7:0]  line_frame [MAX_FRAME];
  bit          written [MAX_FRAME];
  logic [2:0]  line_phase = PH_IDLE;
  logic [6:0]  byte_pos = '0;
  logic [3:0]  attempts = '0;
  logic [14:0] backoff_ticks = '0;
  logic [7:0]  copies_sent = '0;
  cfg_t        regs = '{fpm: 8'd1, flen: 7'd1, jam: 8'd0, mbe: 4'd10};

  res_t        pending_results [$];
  res_t        oldest;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;

  csma_cd_frame_transmitter dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // A collision raises the attempt count up to the limit and picks a backoff.
  function automatic void arm_backoff(input logic [15:0] rnd);
    int cap;
    int nxt;
    int modulus;
    cap = (regs.mbe != 0) ? int'(regs.mbe) : 1;
    nxt = int'(attempts) + 1;
    if (nxt > cap) nxt = cap;
    attempts = 4'(nxt);
    modulus = (1 << attempts) - 1;
    backoff_ticks = 15'(int'(rnd) % modulus);
    byte_pos = '0;
    line_phase = (backoff_ticks != 0) ? PH_BACKOFF : PH_WAIT;
  endfunction

  // Applies one item to the predicted state and returns the result it causes.
  function automatic res_t next_line_result(input item_t it);
    res_t r;
    int len;
    int fpm;
    logic [7:0] sent;
    r = '0;
    len = (regs.flen == 0) ? 1 : ((regs.flen > MAX_FRAME) ? MAX_FRAME : int'(regs.flen));
    fpm = (regs.fpm == 0) ? 1 : int'(regs.fpm);
    case (it.operation)
      OP_LOAD: begin
        line_frame[it.load_index] = it.data_byte;
        written[it.load_index] = 1'b1;
      end
      OP_START: begin
        if (line_phase == PH_IDLE) begin
          line_phase = PH_WAIT;
          copies_sent = '0;
          attempts = '0;
          byte_pos = '0;
          backoff_ticks = '0;
        end
      end
      OP_TICK: begin
        case (line_phase)
          PH_WAIT: begin
            if (!it.line_busy) begin
              r.tx_valid = 1'b1;
              r.tx_byte = line_frame[0];
              byte_pos = 7'd1;
              line_phase = PH_SEND;
            end
          end
          PH_SEND: begin
            sent = line_frame[6'(byte_pos - 1)];
            if (it.line_byte != sent) begin
              r.tx_valid = 1'b1;
              r.tx_byte = regs.jam;
              r.jamming = 1'b1;
              r.collision = 1'b1;
              byte_pos = 7'd1;
              line_phase = PH_JAM;
              if (len <= 1) arm_backoff(it.random_value);
            end else if (byte_pos < len) begin
              r.tx_valid = 1'b1;
              r.tx_byte = line_frame[byte_pos[5:0]];
              byte_pos = byte_pos + 7'd1;
            end else begin
              // Clean frame: this tick is also the gap before the next copy.
              r.frame_sent = 1'b1;
              attempts = '0;
              byte_pos = '0;
              copies_sent = copies_sent + 8'd1;
              if (copies_sent >= fpm) begin
                r.message_done = 1'b1;
                line_phase = PH_IDLE;
              end else begin
                line_phase = PH_WAIT;
              end
            end
          end
          PH_JAM: begin
            r.tx_valid = 1'b1;
            r.tx_byte = regs.jam;
            r.jamming = 1'b1;
            byte_pos = byte_pos + 7'd1;
            if (byte_pos >= len) arm_backoff(it.random_value);
          end
          PH_BACKOFF: begin
            if (backoff_ticks != 0) backoff_ticks = backoff_ticks - 15'd1;
            if (backoff_ticks == 0) line_phase = PH_WAIT;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.attempt_count = attempts;
    r.active = (line_phase != PH_IDLE);
    return r;
  endfunction

  // Mostly well-formed traffic: correct readback with occasional collisions,
  // plus loads, stray starts and unknown operations as noise.
  function automatic item_t random_item(input int coll_pct);
    item_t it;
    int pick;
    it.operation = OP_TICK;
    it.load_index = 6'($urandom);
    it.data_byte = 8'($urandom);
    it.line_busy = ($urandom_range(99) < 30);
    it.line_byte = 8'($urandom);
    it.random_value = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 7) begin
      it.operation = OP_LOAD;
    end else if (pick < 10) begin
      it.operation = OP_NONE;
    end else if (line_phase == PH_IDLE) begin
      if (pick < 60) it.operation = OP_START;
    end else if (pick < 13) begin
      it.operation = OP_START;
    end else if (line_phase == PH_SEND) begin
      it.line_byte = line_frame[6'(byte_pos - 1)];
      // Collisions stop at five attempts so that backoffs stay short.
      if (attempts < 5 && $urandom_range(99) < coll_pct)
        it.line_byte = it.line_byte ^ 8'($urandom_range(255, 1));
    end
    return it;
  endfunction

  // Offers one item with random gaps and records its expected result.
  task automatic send_item(input item_t it, input bit typed, input res_t want);
    res_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = it.operation;
    s_tdata = {1'b0, it.random_value, it.line_byte, it.line_busy, it.data_byte,
               it.load_index};
    do @(posedge clk); while (!s_tready);
    predicted = next_line_result(it);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
    // The next item, if any and if no gap is drawn, raises tvalid again in this same step.
    s_tvalid = 1'b0;
  endtask

  // Register write in setup and access phases; the predictor takes the value at the access edge.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {index, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      REG_FPM:  regs.fpm = value[7:0];
      REG_FLEN: regs.flen = value[6:0];
      REG_JAM:  regs.jam = value[7:0];
      REG_MBE:  regs.mbe = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // The receiver stalls at random, except during the calm stretch.
  always @(negedge clk) begin
    m_tready = calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: m_tdata %0h, m_tuser %0h", m_tdata, m_tuser);
        mismatch_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("tx_valid", oldest.tx_valid, m_tdata[0]);
        check_field("tx_byte", oldest.tx_byte, m_tdata[8:1]);
        check_field("jamming", oldest.jamming, m_tuser);
        check_field("collision", oldest.collision, m_tdata[9]);
        check_field("frame_sent", oldest.frame_sent, m_tdata[10]);
        check_field("message_done", oldest.message_done, m_tdata[11]);
        check_field("attempt_count", oldest.attempt_count, m_tdata[15:12]);
        check_field("active", oldest.active, m_tdata[16]);
      end
    end
  end

  // Watchdog on cycles in which no transaction of any kind completes.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    int eff;
    int coll;
    logic [7:0] nf;
    logic [6:0] nl;
    logic [7:0] nj;
    logic [3:0] nm;
    item_t it;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      it.operation = plan[i].op;
      it.load_index = plan[i].idx;
      it.data_byte = plan[i].data;
      it.line_busy = plan[i].busy;
      it.line_byte = plan[i].readback;
      it.random_value = plan[i].rnd;
      send_item(it, plan[i].typed, plan[i].want);
    end

    // Register settings change only between batches, with nothing in flight.
    for (int p = 0; p < 10; p++) begin
      while (pending_results.size() != 0) @(negedge clk);
      n = 120;
      case (p)
        0: begin nf = 8'd3;   nl = 7'd4;   nj = 8'hA5; nm = 4'd10; coll = 25; end
        1: begin nf = 8'd0;   nl = 7'd0;   nj = 8'hFF; nm = 4'd0;  coll = 30; n = 100; end
        2: begin nf = 8'd255; nl = 7'd2;   nj = 8'h00; nm = 4'd2;  coll = 30; end
        3: begin nf = 8'd2;   nl = 7'd127; nj = 8'h5A; nm = 4'd15; coll = 2;  n = 180; end
        4: begin nf = 8'd1;   nl = 7'd64;  nj = 8'h3C; nm = 4'd1;  coll = 3;  end
        5: begin nf = 8'd5;   nl = 7'd3;   nj = 8'hC3; nm = 4'd4;  coll = 20; end
        default: begin
          nf = 8'($urandom_range(6, 1));
          nl = 7'($urandom_range(8, 1));
          nj = 8'($urandom);
          nm = 4'($urandom_range(15, 1));
          coll = $urandom_range(25, 5);
          n = 110;
        end
      endcase
      calm = (p == 3);
      write_reg(REG_FPM, {24'd0, nf});
      write_reg(REG_FLEN, {25'd0, nl});
      write_reg(REG_JAM, {24'd0, nj});
      write_reg(REG_MBE, {28'd0, nm});

      // Every byte the frame can reach must be loaded before it is sent.
      eff = (nl == 0) ? 1 : ((nl > MAX_FRAME) ? MAX_FRAME : int'(nl));
      for (int i = 0; i < eff; i++) begin
        if (!written[i]) begin
          it = random_item(0);
          it.operation = OP_LOAD;
          it.load_index = 6'(i);
          send_item(it, 1'b0, RES_NONE);
        end
      end
      repeat (n) send_item(random_item(coll), 1'b0, RES_NONE);
    end

    s_tvalid = 1'b0;
    calm = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
